### hdl/gmdis_pkg.sv
// shared types and constants for the greedy minimum-degree independent set block
// word structs for the input and result channels, state codes
// no dependencies
package gmdis_pkg;

  localparam int VCNT_W = 7;
  localparam int VTX_W  = 6;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ARC   = 2'd1,
    MODE_SOLVE = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [VTX_W-1:0]  from_vertex;
    logic [VTX_W-1:0]  to_vertex;
  } in_word_t;

  typedef struct packed {
    logic [VTX_W-1:0]  chosen_vertex;
    logic              is_last;
    logic              is_empty;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARC,
    ST_SCAN,
    ST_PICK,
    ST_EMPTY
  } state_t;

endpackage

### hdl/greedy_min_degree_independent_set.sv
// greedy minimum-degree maximal independent set over a stored adjacency matrix
// row memory with per-row valid bits, one shared popcount/compare unit, small sequencer
// depends on gmdis_pkg
// sequence: clear writes the valid bits; arc does a row read then a row write; solve with n
//   vertices scans every vertex per chosen vertex (one row read and popcount-compare per cycle
//   through the shared unit), then picks the vertex; output stalls hold the pick
// throughput: one input word at a time; the next word is taken once the sequencer is idle
// reset: synchronous active-low; clears the row valid bits (matrix reads as zero),
//   vertex_count, the sequencer and the output valid flag
module greedy_min_degree_independent_set
  import gmdis_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_word_t            in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output out_word_t           out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [VCNT_W-1:0]   cfg_data
);

  localparam int NV = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;
  localparam int IW = (NV > 1) ? $clog2(NV) : 1;
  localparam int DW = $clog2(NV + 2);
  localparam logic [VCNT_W-1:0] NV_L = VCNT_W'(NV);

  // storage
  logic [NV-1:0]   adj_mem [NV];
  logic [NV-1:0]   rd_data_r;
  logic            rd_valid_r;
  logic [IW-1:0]   rd_addr;
  logic            mem_we;
  logic [NV-1:0]   wr_row;

  logic [NV-1:0]   row_valid_r, row_valid_nxt;
  logic [VCNT_W-1:0] vcnt_r;

  state_t          state_r, state_nxt;
  logic [IW-1:0]   from_r, from_nxt;
  logic [IW-1:0]   to_r, to_nxt;
  logic [IW:0]     n_r, n_nxt;
  logic [NV-1:0]   avail_r, avail_nxt;
  logic [IW:0]     v_r, v_nxt;
  logic            pend_r, pend_nxt;
  logic [IW-1:0]   pend_v_r, pend_v_nxt;
  logic [IW-1:0]   best_r, best_nxt;
  logic [DW-1:0]   best_deg_r, best_deg_nxt;
  logic [NV-1:0]   best_row_r, best_row_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_word_t       out_word_r, out_word_nxt;

  logic [NV-1:0]   rd_row;
  logic [DW-1:0]   deg;
  logic [NV-1:0]   avail_after;
  logic [NV-1:0]   scope_mask;
  logic [VCNT_W-1:0] n_eff;
  logic            in_acc;
  logic            slot_free;
  logic            arc_ok;
  logic            issue;

  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign rd_row = rd_valid_r ? rd_data_r : '0;
  assign n_eff  = (vcnt_r < NV_L) ? vcnt_r : NV_L;
  assign arc_ok = ({1'b0, in_word.from_vertex} < NV_L) && ({1'b0, in_word.to_vertex} < NV_L);
  assign issue  = v_r < n_r;
  assign avail_after = avail_r & ~best_row_r & ~(NV'(1) << best_r);

  // shared popcount unit
  always_comb begin
    deg = '0;
    for (int i = 0; i < NV; i++) begin
      deg = deg + DW'(rd_row[i] & avail_r[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < NV; i++) begin
      scope_mask[i] = (VCNT_W'(i) < n_eff);
    end
  end

  always_comb begin
    if (state_r == ST_SCAN) begin
      rd_addr = v_r[IW-1:0];
    end else begin
      rd_addr = in_word.from_vertex[IW-1:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_word.mode)
            MODE_ARC: begin
              if (arc_ok) begin
                state_nxt = ST_ARC;
              end
            end
            MODE_SOLVE: begin
              state_nxt = (n_eff == '0) ? ST_EMPTY : ST_SCAN;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ARC:   state_nxt = ST_IDLE;
      ST_SCAN: begin
        if (!issue) begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        if (slot_free) begin
          state_nxt = (avail_after == '0) ? ST_IDLE : ST_SCAN;
        end
      end
      ST_EMPTY: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    mem_we        = 1'b0;
    wr_row        = rd_row | (NV'(1) << to_r);
    row_valid_nxt = row_valid_r;
    from_nxt      = from_r;
    to_nxt        = to_r;
    n_nxt         = n_r;
    avail_nxt     = avail_r;
    v_nxt         = v_r;
    pend_nxt      = 1'b0;
    pend_v_nxt    = pend_v_r;
    best_nxt      = best_r;
    best_deg_nxt  = best_deg_r;
    best_row_nxt  = best_row_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_word.mode)
            MODE_CLEAR: row_valid_nxt = '0;
            MODE_ARC: begin
              from_nxt = in_word.from_vertex[IW-1:0];
              to_nxt   = in_word.to_vertex[IW-1:0];
            end
            MODE_SOLVE: begin
              n_nxt        = (IW+1)'(n_eff);
              avail_nxt    = scope_mask;
              v_nxt        = '0;
              best_deg_nxt = '1;
            end
            default: ;
          endcase
        end
      end
      ST_ARC: begin
        mem_we = 1'b1;
        row_valid_nxt[from_r] = 1'b1;
      end
      ST_SCAN: begin
        pend_nxt   = issue;
        pend_v_nxt = v_r[IW-1:0];
        v_nxt      = v_r + (IW+1)'(issue);
        if (pend_r && avail_r[pend_v_r] && (deg < best_deg_r)) begin
          best_nxt     = pend_v_r;
          best_deg_nxt = deg;
          best_row_nxt = rd_row;
        end
      end
      ST_PICK: begin
        if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_word_nxt.chosen_vertex = VTX_W'(best_r);
          out_word_nxt.is_last       = (avail_after == '0);
          out_word_nxt.is_empty      = 1'b0;
          avail_nxt                  = avail_after;
          v_nxt                      = '0;
          best_deg_nxt               = '1;
        end
      end
      ST_EMPTY: begin
        if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_word_nxt.chosen_vertex = '0;
          out_word_nxt.is_last       = 1'b1;
          out_word_nxt.is_empty      = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // row memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      adj_mem[from_r] <= wr_row;
    end
    rd_data_r <= adj_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_valid_r <= '0;
      vcnt_r      <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      avail_r     <= '0;
      rd_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_valid_r <= row_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      avail_r     <= (state_nxt == ST_IDLE) ? '0 : avail_nxt;
      rd_valid_r  <= row_valid_r[rd_addr];
      if (cfg_valid && cfg_ready) begin
        vcnt_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    from_r     <= from_nxt;
    to_r       <= to_nxt;
    n_r        <= n_nxt;
    v_r        <= v_nxt;
    pend_v_r   <= pend_v_nxt;
    best_r     <= best_nxt;
    best_deg_r <= best_deg_nxt;
    best_row_r <= best_row_nxt;
    out_word_r <= out_word_nxt;
  end

  // a pick always has a candidate from the scan
  a_pick_found: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PICK |-> best_deg_r <= DW'(NV))
    else $error("pick without a candidate vertex");

  // scanning only while vertices remain available
  a_scan_avail: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> avail_r != '0)
    else $error("scan with no available vertex");

  // an empty result is the only result of its solve
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.is_empty |-> out_word_r.is_last && out_word_r.chosen_vertex == '0)
    else $error("empty result not marked last");

  // a picked vertex leaves the available set
  a_pick_removes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PICK && slot_free |=> !avail_r[$past(best_r)])
    else $error("picked vertex still available");

endmodule
